@@ design/assert_macros.svh @@
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TBS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tbs_pkg.sv @@
package tbs_pkg;

	localparam int ADDR_W    = 16;
	localparam int DIM_W     = 9;
	localparam int COORD_W   = 17;
	localparam int FRAC_W    = 16;
	localparam int TEXEL_W   = 24;
	localparam int CMD_DEPTH = 2;
	localparam int RSP_DEPTH = 4;

	localparam logic [COORD_W-1:0] ONE_Q16 = 17'h10000;

	// configuration register indexes
	localparam logic REG_TEX_WIDTH  = 1'b0;
	localparam logic REG_TEX_HEIGHT = 1'b1;

	typedef struct packed {
		logic                 action;
		logic [ADDR_W-1:0]    texel_index;
		logic [7:0]           texel_red;
		logic [7:0]           texel_green;
		logic [7:0]           texel_blue;
		logic [COORD_W-1:0]   coord_u;
		logic [COORD_W-1:0]   coord_v;
	} req_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} rsp_t;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_WHITE  = 2'd2
	} cmd_kind_t;

	// one classified item between front and back
	typedef struct packed {
		cmd_kind_t                    kind;
		logic [3:0][ADDR_W-1:0]       addr;   // 00,10,01,11; write uses [0]
		logic [FRAC_W-1:0]            tx;
		logic [FRAC_W-1:0]            ty;
		logic [TEXEL_W-1:0]           texel;
	} cmd_t;

endpackage

@@ design/tbs_queue.sv @@
module tbs_queue #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_data,
	output logic  full,
	input  logic  pop,
	output item_t pop_data,
	output logic  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          slots_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ design/tbs_front.sv @@
module tbs_front import tbs_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              cmd_push,
	output cmd_t              cmd,
	input  logic              cmd_full
);

	localparam int DIM_MAX = (1 << DIM_W) - 1;
	localparam logic [DIM_W:0] WCAP = (MAX_WIDTH  > DIM_MAX) ? (DIM_W+1)'(DIM_MAX)
	                                                         : (DIM_W+1)'(MAX_WIDTH);
	localparam logic [DIM_W:0] HCAP = (MAX_HEIGHT > DIM_MAX) ? (DIM_W+1)'(DIM_MAX)
	                                                         : (DIM_W+1)'(MAX_HEIGHT);
	localparam int SW = COORD_W + DIM_W;   // scaled coordinate, Q.16
	localparam int RW = 2 * DIM_W;         // row base y*w

	logic [DIM_W-1:0] tex_width_q, tex_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= '0;
			tex_height_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEX_WIDTH:  tex_width_q  <= cfg_data;
				REG_TEX_HEIGHT: tex_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- stage 1: clamp and scale ----
	logic               accept, adv1, adv2;
	logic [DIM_W-1:0]   weff, heff;
	logic [COORD_W-1:0] uc, vc;
	logic [SW-1:0]      xs, ys;

	assign weff = ({1'b0, tex_width_q}  > WCAP) ? WCAP[DIM_W-1:0] : tex_width_q;
	assign heff = ({1'b0, tex_height_q} > HCAP) ? HCAP[DIM_W-1:0] : tex_height_q;
	assign uc   = (req.coord_u > ONE_Q16) ? ONE_Q16 : req.coord_u;
	assign vc   = (req.coord_v > ONE_Q16) ? ONE_Q16 : req.coord_v;
	assign xs   = SW'(uc) * SW'(weff - DIM_W'(1));
	assign ys   = SW'(vc) * SW'(heff - DIM_W'(1));

	logic             valid_s1, white_s1;
	req_t             item_s1;
	logic [SW-1:0]    xs_s1, ys_s1;
	logic [DIM_W-1:0] weff_s1, heff_s1;

	logic valid_s2;

	assign adv2      = !valid_s2 || !cmd_full;
	assign adv1      = !valid_s1 || adv2;
	assign req_stall = !adv1;
	assign accept    = req_valid && adv1;
	assign cmd_push  = valid_s2 && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1  <= req;
			xs_s1    <= xs;
			ys_s1    <= ys;
			weff_s1  <= weff;
			heff_s1  <= heff;
			white_s1 <= (tex_width_q == '0) || (tex_height_q == '0);
		end
	end

	// ---- stage 2: neighbours, clamp to edge, linear addresses ----
	logic [DIM_W-1:0] x0, y0, x1, y1;
	logic [DIM_W:0]   x1n, y1n;
	logic [RW-1:0]    row0, row1;
	logic [RW:0]      s00, s10, s01, s11;
	cmd_t             cmd_d;

	assign x0   = xs_s1[FRAC_W+DIM_W-1:FRAC_W];
	assign y0   = ys_s1[FRAC_W+DIM_W-1:FRAC_W];
	assign x1n  = {1'b0, x0} + (DIM_W+1)'(1);
	assign y1n  = {1'b0, y0} + (DIM_W+1)'(1);
	assign x1   = (x1n >= {1'b0, weff_s1}) ? weff_s1 - DIM_W'(1) : x1n[DIM_W-1:0];
	assign y1   = (y1n >= {1'b0, heff_s1}) ? heff_s1 - DIM_W'(1) : y1n[DIM_W-1:0];
	assign row0 = RW'(y0) * RW'(weff_s1);
	assign row1 = RW'(y1) * RW'(weff_s1);
	assign s00  = (RW+1)'(x0) + (RW+1)'(row0);
	assign s10  = (RW+1)'(x1) + (RW+1)'(row0);
	assign s01  = (RW+1)'(x0) + (RW+1)'(row1);
	assign s11  = (RW+1)'(x1) + (RW+1)'(row1);

	always_comb begin
		cmd_d.kind    = !item_s1.action ? CMD_WRITE : (white_s1 ? CMD_WHITE : CMD_SAMPLE);
		cmd_d.addr[0] = !item_s1.action ? item_s1.texel_index : s00[ADDR_W-1:0];
		cmd_d.addr[1] = s10[ADDR_W-1:0];
		cmd_d.addr[2] = s01[ADDR_W-1:0];
		cmd_d.addr[3] = s11[ADDR_W-1:0];
		cmd_d.tx      = xs_s1[FRAC_W-1:0];
		cmd_d.ty      = ys_s1[FRAC_W-1:0];
		cmd_d.texel   = {item_s1.texel_red, item_s1.texel_green, item_s1.texel_blue};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			cmd <= cmd_d;
		end
	end

endmodule

@@ design/tbs_back.sv @@
module tbs_back import tbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic rsp_take,
	output logic res_push,
	output rsp_t res
);

	localparam int UW  = $clog2(RSP_DEPTH + 1);
	localparam int WW  = 2 * FRAC_W + 1;     // weight up to 1.0 in Q.32
	localparam int AW  = 40;                 // 255 * 2^32 plus rounding half
	localparam logic [AW-1:0] ROUND = AW'(64'h8000_0000);

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic white;
	} blend_tag_t;

	logic [1:0]    phase_q;
	logic [UW-1:0] used_q;
	logic          start_ok, start, rd_issue, mem_we;
	blend_tag_t    tag_d;

	assign start_ok = (used_q < UW'(RSP_DEPTH));

	// sequencer: one memory access per cycle, held while a new sample finds no free result slot
	always_comb begin
		cmd_pop  = 1'b0;
		start    = 1'b0;
		rd_issue = 1'b0;
		mem_we   = 1'b0;
		tag_d    = '0;
		if (cmd_valid) begin
			unique case (cmd.kind)
				CMD_WRITE: begin
					mem_we  = 1'b1;
					cmd_pop = 1'b1;
				end
				CMD_WHITE: begin
					if (start_ok) begin
						start       = 1'b1;
						cmd_pop     = 1'b1;
						tag_d.valid = 1'b1;
						tag_d.first = 1'b1;
						tag_d.last  = 1'b1;
						tag_d.white = 1'b1;
					end
				end
				CMD_SAMPLE: begin
					if (phase_q != 2'd0 || start_ok) begin
						rd_issue    = 1'b1;
						start       = (phase_q == 2'd0);
						cmd_pop     = (phase_q == 2'd3);
						tag_d.valid = 1'b1;
						tag_d.first = (phase_q == 2'd0);
						tag_d.last  = (phase_q == 2'd3);
					end
				end
				default: begin
					cmd_pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			used_q  <= '0;
		end else begin
			if (rd_issue) begin
				phase_q <= phase_q + 2'd1;
			end
			used_q <= used_q + UW'(start) - UW'(rsp_take);
		end
	end

	// texel memory, single port, registered read
	logic [TEXEL_W-1:0] texels [2**ADDR_W];
	logic [ADDR_W-1:0]  mem_addr;
	logic [TEXEL_W-1:0] rd_s1;

	assign mem_addr = mem_we ? cmd.addr[0] : cmd.addr[phase_q];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			texels[mem_addr] <= cmd.texel;
		end
		rd_s1 <= texels[mem_addr];
	end

	// bilinear weight of the texel being fetched
	logic [COORD_W-1:0]   wx, wy;
	logic [2*COORD_W-1:0] wprod;
	logic [WW-1:0]        weight_s1;
	blend_tag_t           tag_s1, tag_s2;

	assign wx    = phase_q[0] ? {1'b0, cmd.tx} : ONE_Q16 - {1'b0, cmd.tx};
	assign wy    = phase_q[1] ? {1'b0, cmd.ty} : ONE_Q16 - {1'b0, cmd.ty};
	assign wprod = (2*COORD_W)'(wx) * (2*COORD_W)'(wy);

	always_ff @(posedge clk) begin
		weight_s1 <= wprod[WW-1:0];
	end

	// per-channel product
	logic [2:0][AW-1:0] prod_s2;

	always_ff @(posedge clk) begin
		prod_s2[0] <= AW'(rd_s1[23:16]) * AW'(weight_s1);
		prod_s2[1] <= AW'(rd_s1[15:8])  * AW'(weight_s1);
		prod_s2[2] <= AW'(rd_s1[7:0])   * AW'(weight_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_d;
			tag_s2 <= tag_s1;
		end
	end

	// accumulate the four products of a sample; rounding half seeded on the first
	logic [2:0][AW-1:0] acc_q, acc_d;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc_d[c] = (tag_s2.first ? ROUND : acc_q[c]) + prod_s2[c];
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			acc_q <= acc_d;
		end
	end

	assign res_push      = tag_s2.valid && tag_s2.last;
	assign res.out_red   = tag_s2.white ? 8'hFF : acc_d[0][AW-1:AW-8];
	assign res.out_green = tag_s2.white ? 8'hFF : acc_d[1][AW-1:AW-8];
	assign res.out_blue  = tag_s2.white ? 8'hFF : acc_d[2][AW-1:AW-8];

endmodule

@@ design/bilinear_texture_sampler.sv @@
// channel  dir  handshake              item
// -------  ---  ---------------------  ---------------------------------------
// req      in   req_valid / req_stall  req_t: write texel or sample at u,v
// rsp      out  rsp_valid / rsp_stall  rsp_t: filtered RGB, one per sample
// cfg      in   cfg_valid / cfg_ready  index 0 tex_width, 1 tex_height
//
// A sample holds the single texel memory port for one fetch per neighbour,
// a write for one access; the next command can use the port as soon as a
// sample's last fetch is issued, while that sample is still being blended.
// arst_n clears control state and the size registers; texels are not cleared.
// Front and back are split by a 2-item queue; the back only starts a sample
// when the 4-entry result queue has a slot reserved, so rsp_stall never
// stalls the blend pipeline, it backs up into req_stall.
module bilinear_texture_sampler import tbs_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp
);

	// front -> queue
	logic cmd_push, cmd_full;
	cmd_t cmd_in;

	// queue -> back
	logic cmd_pop, cmd_empty;
	cmd_t cmd_head;

	// back -> result queue
	logic res_push, rsp_empty, rsp_take;
	rsp_t res;

	// front: size registers, coordinate scaling, clamp-to-edge addressing
	tbs_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	// decoupling queue between classification and memory work
	tbs_queue #(
		.item_t (cmd_t),
		.DEPTH  (CMD_DEPTH)
	) u_cmd_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.pop_data  (cmd_head),
		.empty     (cmd_empty)
	);

	// back: texel memory, fetch sequencer, weighted blend
	tbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.rsp_take  (rsp_take),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue; slots are reserved by the back before a sample starts
	tbs_queue #(
		.item_t (rsp_t),
		.DEPTH  (RSP_DEPTH)
	) u_rsp_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.full      (),
		.pop       (rsp_take),
		.pop_data  (rsp),
		.empty     (rsp_empty)
	);

	assign rsp_valid = !rsp_empty;
	assign rsp_take  = rsp_valid && !rsp_stall;

endmodule

@@ design/tbs_checker.sv @@
`include "assert_macros.svh"

module tbs_checker import tbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a result waiting on the consumer stays put
	`TBS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "rsp changed while stalled")

	// reset empties the result queue
	`TBS_ASSERT_ALWAYS(a_rst_empty, !arst_n |=> !rsp_valid, "result visible in reset")

	// input stall only comes from an item taken earlier and still held
	`TBS_ASSERT(a_stall_cause, req_stall |-> $past(req_valid && !req_stall) || $past(req_stall), "req_stall with nothing in flight")

endmodule

bind bilinear_texture_sampler tbs_checker u_tbs_checker (.*);
